### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// Clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tcsv_pkg.sv
// ----------------------------------------------------------------------------
// tcsv_pkg
// Types, constants and helpers of the tiltmeter CSV line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tcsv_pkg;

    localparam int CHECKED_TOKENS = 4;
    localparam int MAX_TOKENS     = 5;
    localparam int MIN_ROOM       = 4;

    localparam int CHAR_W  = 8;
    localparam int VOLT_W  = 32;
    localparam int ACCEL_W = 27;
    localparam int TEMP_W  = 17;
    localparam int ROOM_W  = 8;
    localparam int MINLEN_W = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef logic [2:0] tok_idx_t;
    typedef logic [3:0] tok_len_t;
    typedef logic [1:0] tok_slot_t;

    localparam tok_len_t LEN_CAP = 4'd14;

    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ROOM    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LINE_LENGTH = 1'd1;

    localparam logic [ROOM_W-1:0]   ROOM_RESET   = 8'd4;
    localparam logic [MINLEN_W-1:0] MINLEN_RESET = 7'd30;

    localparam tok_len_t TOK_MIN_LEN [CHECKED_TOKENS] = '{4'd1, 4'd8, 4'd8, 4'd5};
    localparam tok_len_t TOK_MAX_LEN [CHECKED_TOKENS] = '{4'd13, 4'd8, 4'd8, 4'd5};

    typedef struct packed {
        logic enough_tokens;
        logic token_error;
    } tok_status_t;

    function automatic tok_slot_t tok_slot(tok_idx_t idx);
        return tok_slot_t'(idx - 3'd1);
    endfunction

    function automatic logic len_ok(tok_slot_t k, tok_len_t len);
        return (len >= TOK_MIN_LEN[k]) && (len <= TOK_MAX_LEN[k]);
    endfunction

    // a * 10 + d, wrapped to 32 bits
    function automatic logic [31:0] mul10_add(logic [31:0] a, logic [3:0] d);
        return (a << 3) + (a << 1) + {28'd0, d};
    endfunction

endpackage

`default_nettype wire

### rtl/core/tcsv_in_if.sv
// ----------------------------------------------------------------------------
// tcsv_in_if
// Byte channel into the parser: one line byte and its end flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcsv_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcsv_pkg::CHAR_W-1:0]   char_byte;
    logic                          line_end;

    modport source (output valid, output char_byte, output line_end, input ready);
    modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

`default_nettype wire

### rtl/core/tcsv_out_if.sv
// ----------------------------------------------------------------------------
// tcsv_out_if
// Result channel of the parser: verdict and four samples per line.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcsv_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 line_ok;
    logic signed [tcsv_pkg::VOLT_W-1:0]   voltage_sample;
    logic [tcsv_pkg::ACCEL_W-1:0]         accel_y_sample;
    logic [tcsv_pkg::ACCEL_W-1:0]         accel_x_sample;
    logic [tcsv_pkg::TEMP_W-1:0]          temperature_sample;

    modport source (output valid, output line_ok, output voltage_sample,
                    output accel_y_sample, output accel_x_sample,
                    output temperature_sample, input ready);
    modport sink   (input valid, input line_ok, input voltage_sample,
                    input accel_y_sample, input accel_x_sample,
                    input temperature_sample, output ready);
endinterface

`default_nettype wire

### rtl/core/tcsv_tokenizer.sv
// ----------------------------------------------------------------------------
// tcsv_tokenizer
// Comma tokenizer with per-token length/digit check and decimal accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsv_tokenizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              tokenize,
    input  logic [tcsv_pkg::CHAR_W-1:0]       char_byte,
    input  logic                              line_end,
    output tcsv_pkg::tok_status_t             status,
    output logic [tcsv_pkg::VOLT_W-1:0]       volt_acc,
    output logic [tcsv_pkg::ACCEL_W-1:0]      accy_acc,
    output logic [tcsv_pkg::ACCEL_W-1:0]      accx_acc,
    output logic [tcsv_pkg::TEMP_W-1:0]       temp_acc
);
    import tcsv_pkg::*;

    tok_idx_t             idx_reg,  idx_next;
    tok_len_t             len_reg,  len_next;
    logic                 open_reg, open_next;
    logic                 err_reg,  err_next;
    logic [VOLT_W-1:0]    volt_reg, volt_next;
    logic [ACCEL_W-1:0]   accy_reg, accy_next;
    logic [ACCEL_W-1:0]   accx_reg, accx_next;
    logic [TEMP_W-1:0]    temp_reg, temp_next;

    logic                 is_comma;
    logic                 is_digit;
    logic                 active;
    tok_slot_t            slot;
    logic [31:0]          acc_sel;
    logic [31:0]          acc_upd;

    assign is_comma = (char_byte == CHAR_COMMA);
    assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);

    always_comb
    begin
        idx_next  = idx_reg;
        len_next  = len_reg;
        open_next = open_reg;
        err_next  = err_reg;
        volt_next = volt_reg;
        accy_next = accy_reg;
        accx_next = accx_reg;
        temp_next = temp_reg;
        active    = 1'b0;
        slot      = tok_slot(idx_reg);
        acc_sel   = 32'd0;
        acc_upd   = 32'd0;

        if (tokenize)
        begin
            if (is_comma)
            begin
                if (open_reg && idx_reg >= 3'd1 && idx_reg <= 3'(CHECKED_TOKENS)
                    && !len_ok(slot, len_reg))
                begin
                    err_next = 1'b1;
                end
                open_next = 1'b0;
            end
            else
            begin
                if (!open_reg && idx_reg < 3'(MAX_TOKENS))
                begin
                    idx_next  = idx_reg + 3'd1;
                    open_next = 1'b1;
                    len_next  = '0;
                end
                active = open_next && (idx_next <= 3'(CHECKED_TOKENS));
                slot   = tok_slot(idx_next);
                if (active)
                begin
                    if (len_next != LEN_CAP)
                    begin
                        len_next = len_next + 4'd1;
                    end
                    case (slot)
                        2'd0:    acc_sel = volt_reg;
                        2'd1:    acc_sel = {5'd0, accy_reg};
                        2'd2:    acc_sel = {5'd0, accx_reg};
                        2'd3:    acc_sel = {15'd0, temp_reg};
                        default: acc_sel = 32'd0;
                    endcase
                    acc_upd = mul10_add(acc_sel, 4'(char_byte - CHAR_ZERO));
                    if (!is_digit)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        case (slot)
                            2'd0:    volt_next = acc_upd;
                            2'd1:    accy_next = acc_upd[ACCEL_W-1:0];
                            2'd2:    accx_next = acc_upd[ACCEL_W-1:0];
                            2'd3:    temp_next = acc_upd[TEMP_W-1:0];
                            default: volt_next = volt_reg;
                        endcase
                    end
                end
            end
        end
    end

    // Line-end view: close the open token on top of this byte's update
    assign status.enough_tokens = (idx_next >= 3'(CHECKED_TOKENS));
    assign status.token_error   = err_next ||
        (open_next && idx_next >= 3'd1 && idx_next <= 3'(CHECKED_TOKENS)
         && !len_ok(tok_slot(idx_next), len_next));

    assign volt_acc = volt_next;
    assign accy_acc = accy_next;
    assign accx_acc = accx_next;
    assign temp_acc = temp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            len_reg  <= '0;
            open_reg <= 1'b0;
            err_reg  <= 1'b0;
            volt_reg <= '0;
            accy_reg <= '0;
            accx_reg <= '0;
            temp_reg <= '0;
        end
        else if (advance)
        begin
            if (line_end)
            begin
                idx_reg  <= '0;
                len_reg  <= '0;
                open_reg <= 1'b0;
                err_reg  <= 1'b0;
                volt_reg <= '0;
                accy_reg <= '0;
                accx_reg <= '0;
                temp_reg <= '0;
            end
            else
            begin
                idx_reg  <= idx_next;
                len_reg  <= len_next;
                open_reg <= open_next;
                err_reg  <= err_next;
                volt_reg <= volt_next;
                accy_reg <= accy_next;
                accx_reg <= accx_next;
                temp_reg <= temp_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/tilt_csv_line_parser_unit.sv
// ----------------------------------------------------------------------------
// tilt_csv_line_parser_unit
// Byte-serial parser for comma-separated tiltmeter lines.
// ----------------------------------------------------------------------------
// The block takes one byte of a sensor line per item on in_ch, with line_end
// set on the last byte, and returns one result item on out_ch per line: a
// pass/reject flag and the four decoded samples (voltage, accel Y, accel X,
// temperature), all zero on reject. A line passes when channel_room is at
// least four, the line holds at least min_line_length bytes, at least four
// non-empty tokens were seen, and the first four tokens are all digits with
// lengths 1-13, 8, 8 and 5. Runs of commas make no empty tokens, a fifth token
// is ignored, and only the first BUFFER_BYTES-1 bytes are tokenized (later
// bytes still count toward the length). A zero byte ends the line's text:
// it and the following bytes of that line are neither counted nor parsed.
// Rate: one item per clock while no line-end byte stalls. Each byte passes an
// input register and then the tokenizer logic (compare, multiply-by-ten add),
// whose line-end verdict is written into the output register. The output
// register lets bytes keep flowing while a result waits; only a line-end byte
// stalls, in the input register, while the previous result is still untaken.
// Configuration (index 0: channel_room, index 1: min_line_length) must be
// written by the user through cfg_we / cfg_index / cfg_data only while no line
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_csv_line_parser_unit #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tcsv_in_if.sink                             in_ch,
    tcsv_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [tcsv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcsv_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tcsv_pkg::*;

    // Byte counter must cover both the tokenizing window and min_line_length
    localparam int WIN_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W = (WIN_W > MINLEN_W) ? WIN_W : MINLEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX    = '1;
    localparam logic [CNT_W-1:0] WINDOW_END = CNT_W'(BUFFER_BYTES - 1);

    // Configuration registers
    logic [ROOM_W-1:0]    room_reg;
    logic [MINLEN_W-1:0]  minlen_reg;

    // Input register
    logic                 s1_valid_reg;
    logic [CHAR_W-1:0]    s1_byte_reg;
    logic                 s1_last_reg;

    // Line state kept here; token state lives in the tokenizer
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 nul_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic [VOLT_W-1:0]    out_volt_reg;
    logic [ACCEL_W-1:0]   out_accy_reg;
    logic [ACCEL_W-1:0]   out_accx_reg;
    logic [TEMP_W-1:0]    out_temp_reg;

    logic                 out_free;
    logic                 s1_adv;
    logic                 in_take;
    logic                 effective;
    logic                 tokenize;
    logic                 line_ok;

    tok_status_t          tok_status;
    logic [VOLT_W-1:0]    volt_acc;
    logic [ACCEL_W-1:0]   accy_acc;
    logic [ACCEL_W-1:0]   accx_acc;
    logic [TEMP_W-1:0]    temp_acc;

    // Handshake: a plain byte always moves on; a line-end byte waits for room
    // in the output register.
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_adv      = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_take     = in_ch.valid && in_ch.ready;

    // Drop the byte once a zero byte has ended the text of this line
    assign effective = !nul_reg && (s1_byte_reg != CHAR_NUL);
    assign tokenize  = effective && (cnt_reg < WINDOW_END);
    assign cnt_next  = (effective && cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;

    tcsv_tokenizer u_tok (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_adv),
        .tokenize  (tokenize),
        .char_byte (s1_byte_reg),
        .line_end  (s1_last_reg),
        .status    (tok_status),
        .volt_acc  (volt_acc),
        .accy_acc  (accy_acc),
        .accx_acc  (accx_acc),
        .temp_acc  (temp_acc)
    );

    assign line_ok = (room_reg >= ROOM_W'(MIN_ROOM))
                  && (cnt_next >= CNT_W'(minlen_reg))
                  && tok_status.enough_tokens
                  && !tok_status.token_error;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_reg   <= ROOM_RESET;
            minlen_reg <= MINLEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNEL_ROOM:    room_reg   <= cfg_data;
                CFG_MIN_LINE_LENGTH: minlen_reg <= cfg_data[MINLEN_W-1:0];
                default:             room_reg   <= room_reg;
            endcase
        end
    end

    // Input register: load whenever the stage is free or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_ch.char_byte;
            s1_last_reg <= in_ch.line_end;
        end
    end

    // Line length and zero-byte flag; clear at the end of each line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            nul_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                cnt_reg <= '0;
                nul_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                nul_reg <= nul_reg || (s1_byte_reg == CHAR_NUL);
            end
        end
    end

    // Output register: hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            out_ok_reg   <= line_ok;
            out_volt_reg <= line_ok ? volt_acc : '0;
            out_accy_reg <= line_ok ? accy_acc : '0;
            out_accx_reg <= line_ok ? accx_acc : '0;
            out_temp_reg <= line_ok ? temp_acc : '0;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.line_ok            = out_ok_reg;
    assign out_ch.voltage_sample     = $signed(out_volt_reg);
    assign out_ch.accel_y_sample     = out_accy_reg;
    assign out_ch.accel_x_sample     = out_accx_reg;
    assign out_ch.temperature_sample = out_temp_reg;

endmodule

`default_nettype wire

### rtl/core/tcsv_checker.sv
// ----------------------------------------------------------------------------
// tcsv_checker
// Port-level checks of the line parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcsv_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                in_line_end,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                line_ok,
    input  logic [tcsv_pkg::VOLT_W-1:0]         voltage_sample,
    input  logic [tcsv_pkg::ACCEL_W-1:0]        accel_y_sample,
    input  logic [tcsv_pkg::ACCEL_W-1:0]        accel_x_sample,
    input  logic [tcsv_pkg::TEMP_W-1:0]         temperature_sample
);
    import tcsv_pkg::*;

    // Lines accepted whose result has not been taken yet
    logic [1:0] pending_reg, pending_next;
    logic       line_in;
    logic       result_out;

    assign line_in    = in_valid && in_ready && in_line_end;
    assign result_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (line_in && !result_out)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!line_in && result_out)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ASSERT_ALWAYS(a_result_has_line, !out_valid || pending_reg != 2'd0, "result without a line end")

    `ASSERT_ALWAYS(a_two_lines_max, pending_reg != 2'd3, "more than two lines in flight")

    `ASSERT_ALWAYS(a_reject_zero, !(out_valid && !line_ok) || (voltage_sample == '0 && accel_y_sample == '0 && accel_x_sample == '0 && temperature_sample == '0), "rejected line with nonzero samples")

    `ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(line_ok) && $stable(voltage_sample), "stalled result changed")

endmodule

bind tilt_csv_line_parser_unit tcsv_checker u_tcsv_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_line_end        (in_ch.line_end),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .line_ok            (out_ch.line_ok),
    .voltage_sample     (out_ch.voltage_sample),
    .accel_y_sample     (out_ch.accel_y_sample),
    .accel_x_sample     (out_ch.accel_x_sample),
    .temperature_sample (out_ch.temperature_sample)
);

`default_nettype wire
